// ===== rtl/core/dcq_pkg.sv =====
// dcq_pkg: shared types and codes for the delayed command queue.
// No dependencies; used by delayed_command_queue and dcq_checker.

package dcq_pkg;

   localparam int unsigned MAIN_DEPTH_DEF  = 16;
   localparam int unsigned DELAY_DEPTH_DEF = 16;
   // types at or above this count never take the delay ring
   localparam int unsigned TYPE_COUNT      = 32;

   localparam int unsigned TYPE_W = 5;
   localparam int unsigned WORD_W = 32;

   // item operations
   localparam logic [1:0] OP_SEND  = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // result status
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_DROP  = 2'd2;

   // register indexes
   localparam logic REG_MASK = 1'b0;
   localparam logic REG_CODE = 1'b1;

   typedef struct packed {
      logic [TYPE_W-1:0] mtype;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] pointer;
   } msg_entry_type;

endpackage

// ===== rtl/core/delayed_command_queue.sv =====
// delayed_command_queue: main and delay message rings under a small sequencer.
// Depends on dcq_pkg; checked by dcq_checker (bound in dcq_checker.sv).
//
//  channel   ports                          handshake
//  request   req_op, req_msg_*_in           accepted when start && !busy
//  result    rsp_status .. rsp_delay_pending one cycle, marked by rsp_strobe
//  config    psel/penable/pwrite/paddr/...   written on psel&penable&pwrite
//
// Send, get and clear go from accept in S_IDLE through S_EXEC to the S_RESP
// strobe. A tick with the countdown running only decrements it; otherwise each
// message moved is one main-ring write in S_TICK_EV, then S_TICK_RD waiting
// for the next delay-ring head to come out of the registered delay-ring read.
// Reset is synchronous; both rings come up empty, no clearing pass.
// busy stays high from accept until the result strobe has gone; the receiver
// cannot stall, so no result is ever held back.

module delayed_command_queue #(
   parameter int unsigned MAIN_DEPTH  = dcq_pkg::MAIN_DEPTH_DEF,
   parameter int unsigned DELAY_DEPTH = dcq_pkg::DELAY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [dcq_pkg::TYPE_W-1:0]  req_msg_type_in,
   input  logic [dcq_pkg::WORD_W-1:0]  req_msg_word_in,
   input  logic [dcq_pkg::WORD_W-1:0]  req_msg_pointer_in,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_msg_valid,
   output logic [dcq_pkg::TYPE_W-1:0]  rsp_msg_type_out,
   output logic [dcq_pkg::WORD_W-1:0]  rsp_msg_word_out,
   output logic [dcq_pkg::WORD_W-1:0]  rsp_msg_pointer_out,
   output logic [4:0]                  rsp_delay_pending,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int unsigned MIDX_W  = $clog2(MAIN_DEPTH);
   localparam int unsigned DIDX_W  = $clog2(DELAY_DEPTH);
   localparam int unsigned MFILL_W = $clog2(MAIN_DEPTH + 1);
   localparam int unsigned DFILL_W = $clog2(DELAY_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TICK_RD,
      S_TICK_EV,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]                mask_ff, mask_in;
   logic [dcq_pkg::TYPE_W-1:0] code_ff, code_in;

   logic [1:0]             op_ff, op_in;
   dcq_pkg::msg_entry_type cmd_ff, cmd_in;

   logic [MIDX_W-1:0]  main_rd_ff, main_rd_in, main_wr_ff, main_wr_in;
   logic [MFILL_W-1:0] main_fill_ff, main_fill_in;
   logic [DIDX_W-1:0]  delay_rd_ff, delay_rd_in, delay_wr_ff, delay_wr_in;
   logic [DFILL_W-1:0] delay_fill_ff, delay_fill_in;
   logic [dcq_pkg::WORD_W-1:0] countdown_ff, countdown_in;

   logic [1:0]             status_ff, status_in;
   logic                   valid_ff, valid_in;
   dcq_pkg::msg_entry_type out_ff, out_in;

   dcq_pkg::msg_entry_type main_mem [MAIN_DEPTH];
   dcq_pkg::msg_entry_type delay_mem [DELAY_DEPTH];
   dcq_pkg::msg_entry_type main_rdata_ff, delay_rdata_ff;
   dcq_pkg::msg_entry_type main_wdata;
   logic                   main_we, delay_we;

   logic [MIDX_W-1:0] main_rd_inc, main_wr_inc;
   logic [DIDX_W-1:0] delay_rd_inc, delay_wr_inc;
   logic              main_full, delay_full, delayed;
   logic [dcq_pkg::WORD_W-1:0] dec_operand, dec_result;
   logic [10:0]       dfill_ext;
   logic              cfg_write;

   assign main_rd_inc  = (main_rd_ff == MIDX_W'(MAIN_DEPTH - 1)) ? '0 : main_rd_ff + 1'b1;
   assign main_wr_inc  = (main_wr_ff == MIDX_W'(MAIN_DEPTH - 1)) ? '0 : main_wr_ff + 1'b1;
   assign delay_rd_inc = (delay_rd_ff == DIDX_W'(DELAY_DEPTH - 1)) ? '0 : delay_rd_ff + 1'b1;
   assign delay_wr_inc = (delay_wr_ff == DIDX_W'(DELAY_DEPTH - 1)) ? '0 : delay_wr_ff + 1'b1;

   assign main_full  = (main_fill_ff == MFILL_W'(MAIN_DEPTH));
   assign delay_full = (delay_fill_ff == DFILL_W'(DELAY_DEPTH));
   assign delayed    = (32'(cmd_ff.mtype) < dcq_pkg::TYPE_COUNT) && mask_ff[cmd_ff.mtype];

   // shared decrementer: running countdown, or a delay word being loaded
   assign dec_operand = (state_ff == S_TICK_EV) ? delay_rdata_ff.word : countdown_ff;
   assign dec_result  = dec_operand - 1'b1;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == dcq_pkg::REG_CODE) ? 32'(code_ff) : mask_ff;

   always_comb begin
      mask_in = mask_ff;
      code_in = code_ff;
      if (cfg_write) begin
         if (paddr[2] == dcq_pkg::REG_CODE) begin
            code_in = pwdata[dcq_pkg::TYPE_W-1:0];
         end else begin
            mask_in = pwdata;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd_in        = cmd_ff;
      main_rd_in    = main_rd_ff;
      main_wr_in    = main_wr_ff;
      main_fill_in  = main_fill_ff;
      delay_rd_in   = delay_rd_ff;
      delay_wr_in   = delay_wr_ff;
      delay_fill_in = delay_fill_ff;
      countdown_in  = countdown_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      out_in        = out_ff;
      main_we       = 1'b0;
      delay_we      = 1'b0;
      main_wdata    = cmd_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = req_op;
               cmd_in.mtype   = req_msg_type_in;
               cmd_in.word    = req_msg_word_in;
               cmd_in.pointer = req_msg_pointer_in;
               status_in     = dcq_pkg::STATUS_DONE;
               valid_in      = 1'b0;
               out_in        = '0;
               state_in      = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            case (op_ff)
               dcq_pkg::OP_SEND: begin
                  if (delayed) begin
                     if (delay_full) begin
                        status_in = dcq_pkg::STATUS_DROP;
                     end else begin
                        delay_we      = 1'b1;
                        delay_wr_in   = delay_wr_inc;
                        delay_fill_in = delay_fill_ff + 1'b1;
                     end
                  end else begin
                     if (main_full) begin
                        status_in = dcq_pkg::STATUS_DROP;
                     end else begin
                        main_we      = 1'b1;
                        main_wr_in   = main_wr_inc;
                        main_fill_in = main_fill_ff + 1'b1;
                     end
                  end
               end
               dcq_pkg::OP_GET: begin
                  if (main_fill_ff == '0) begin
                     status_in = dcq_pkg::STATUS_EMPTY;
                  end else begin
                     valid_in     = 1'b1;
                     out_in       = main_rdata_ff;
                     main_rd_in   = main_rd_inc;
                     main_fill_in = main_fill_ff - 1'b1;
                  end
               end
               dcq_pkg::OP_TICK: begin
                  if (countdown_ff != '0) begin
                     countdown_in = dec_result;
                  end else begin
                     state_in = S_TICK_EV;
                  end
               end
               dcq_pkg::OP_CLEAR: begin
                  delay_rd_in   = '0;
                  delay_wr_in   = '0;
                  delay_fill_in = '0;
                  countdown_in  = '0;
               end
               default: ;
            endcase
         end

         // wait for the new delay-ring head to come out of the read register
         S_TICK_RD: begin
            state_in = S_TICK_EV;
         end

         S_TICK_EV: begin
            if (delay_fill_ff == '0) begin
               state_in = S_RESP;
            end else if (delay_rdata_ff.mtype == code_ff) begin
               delay_rd_in   = delay_rd_inc;
               delay_fill_in = delay_fill_ff - 1'b1;
               countdown_in  = (delay_rdata_ff.word == '0) ? '0 : dec_result;
               state_in      = S_RESP;
            end else if (main_full) begin
               state_in = S_RESP;
            end else begin
               main_we       = 1'b1;
               main_wdata    = delay_rdata_ff;
               main_wr_in    = main_wr_inc;
               main_fill_in  = main_fill_ff + 1'b1;
               delay_rd_in   = delay_rd_inc;
               delay_fill_in = delay_fill_ff - 1'b1;
               state_in      = S_TICK_RD;
            end
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mask_ff       <= '0;
         code_ff       <= '0;
         main_rd_ff    <= '0;
         main_wr_ff    <= '0;
         main_fill_ff  <= '0;
         delay_rd_ff   <= '0;
         delay_wr_ff   <= '0;
         delay_fill_ff <= '0;
         countdown_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         code_ff       <= code_in;
         main_rd_ff    <= main_rd_in;
         main_wr_ff    <= main_wr_in;
         main_fill_ff  <= main_fill_in;
         delay_rd_ff   <= delay_rd_in;
         delay_wr_ff   <= delay_wr_in;
         delay_fill_ff <= delay_fill_in;
         countdown_ff  <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      valid_ff  <= valid_in;
      out_ff    <= out_in;
   end

   // ring stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[main_wr_ff] <= main_wdata;
      end
      main_rdata_ff <= main_mem[main_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (delay_we) begin
         delay_mem[delay_wr_ff] <= cmd_ff;
      end
      delay_rdata_ff <= delay_mem[delay_rd_ff];
   end

   assign dfill_ext = 11'(delay_fill_ff);

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = (state_ff == S_RESP);
   assign rsp_status          = status_ff;
   assign rsp_msg_valid       = valid_ff;
   assign rsp_msg_type_out    = out_ff.mtype;
   assign rsp_msg_word_out    = out_ff.word;
   assign rsp_msg_pointer_out = out_ff.pointer;
   assign rsp_delay_pending   = (dfill_ext > 11'd31) ? 5'd31 : dfill_ext[4:0];

endmodule

// ===== rtl/core/dcq_checker.sv =====
// dcq_checker: port-level checks on delayed_command_queue, bound below.
// Depends on dcq_pkg for status codes.

module dcq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_msg_valid,
   input logic [dcq_pkg::TYPE_W-1:0]  rsp_msg_type_out,
   input logic [dcq_pkg::WORD_W-1:0]  rsp_msg_word_out,
   input logic [dcq_pkg::WORD_W-1:0]  rsp_msg_pointer_out
);

   // an accepted item holds the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after item accepted");

   // the result strobe lasts a single cycle and ends the item
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not a single cycle closing the item");

   // a result only appears while an item is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside an item");

   // a returned message always carries status done
   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_msg_valid |-> rsp_status == dcq_pkg::STATUS_DONE)
      else $error("returned message with error status");

   // no message, no message fields
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_msg_valid |->
         rsp_msg_type_out == '0 && rsp_msg_word_out == '0 && rsp_msg_pointer_out == '0)
      else $error("message fields set without a message");

endmodule

bind delayed_command_queue dcq_checker u_dcq_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_status          (rsp_status),
   .rsp_msg_valid       (rsp_msg_valid),
   .rsp_msg_type_out    (rsp_msg_type_out),
   .rsp_msg_word_out    (rsp_msg_word_out),
   .rsp_msg_pointer_out (rsp_msg_pointer_out)
);

// ===== tb/delayed_command_queue_tb.sv =====
// delayed_command_queue_tb: self-checking bench for the delayed command queue.
// Depends on dcq_pkg and delayed_command_queue; a ring mirror class predicts
// each result, and plain tasks drive the item and register ports.

module delayed_command_queue_tb;

   localparam int unsigned MAIN_SLOTS   = dcq_pkg::MAIN_DEPTH_DEF;
   localparam int unsigned DELAY_SLOTS  = dcq_pkg::DELAY_DEPTH_DEF;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 950;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       valid;
      logic [dcq_pkg::TYPE_W-1:0] mtype;
      logic [dcq_pkg::WORD_W-1:0] word;
      logic [dcq_pkg::WORD_W-1:0] pointer;
      logic [4:0]                 pending;
   } dcq_result_type;

   class command_queue_mirror;
      logic [31:0]                enable_mask;
      logic [dcq_pkg::TYPE_W-1:0] delay_code;
      logic [31:0]                countdown;
      dcq_pkg::msg_entry_type     main_ring[$];
      dcq_pkg::msg_entry_type     delay_ring[$];
      dcq_result_type             due_results[$];
      int unsigned                errors;

      function new();
         enable_mask = '0;
         delay_code  = '0;
         countdown   = '0;
         errors      = 0;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%s", what);
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == dcq_pkg::REG_MASK) enable_mask = value;
         else delay_code = value[dcq_pkg::TYPE_W-1:0];
      endfunction

      function logic [31:0] reg_value(logic idx);
         if (idx == dcq_pkg::REG_MASK) return enable_mask;
         return {27'd0, delay_code};
      endfunction

      function int unsigned due_count();
         return due_results.size();
      endfunction

      // countdown running: just decrement; else drain until a delay command, a full main ring or an empty delay ring
      function void run_tick();
         dcq_pkg::msg_entry_type head;
         if (countdown != 0) begin
            countdown--;
            return;
         end
         while (delay_ring.size() != 0) begin
            head = delay_ring[0];
            if (head.mtype == delay_code) begin
               void'(delay_ring.pop_front());
               countdown = (head.word == 0) ? 32'd0 : head.word - 1;
               break;
            end
            if (main_ring.size() >= MAIN_SLOTS) break;
            main_ring.push_back(head);
            void'(delay_ring.pop_front());
         end
      endfunction

      function void accept_item(logic [1:0] op, logic [dcq_pkg::TYPE_W-1:0] t,
                                logic [dcq_pkg::WORD_W-1:0] w,
                                logic [dcq_pkg::WORD_W-1:0] p);
         dcq_result_type         res;
         dcq_pkg::msg_entry_type msg;
         logic                   delayed;
         res = '0;
         msg.mtype = t;
         msg.word = w;
         msg.pointer = p;
         case (op)
            dcq_pkg::OP_SEND: begin
               delayed = (int'(t) < dcq_pkg::TYPE_COUNT) && enable_mask[t];
               if (delayed) begin
                  if (delay_ring.size() >= DELAY_SLOTS) res.status = dcq_pkg::STATUS_DROP;
                  else delay_ring.push_back(msg);
               end else begin
                  if (main_ring.size() >= MAIN_SLOTS) res.status = dcq_pkg::STATUS_DROP;
                  else main_ring.push_back(msg);
               end
            end
            dcq_pkg::OP_GET: begin
               if (main_ring.size() == 0) begin
                  res.status = dcq_pkg::STATUS_EMPTY;
               end else begin
                  msg = main_ring.pop_front();
                  res.valid = 1'b1;
                  res.mtype = msg.mtype;
                  res.word = msg.word;
                  res.pointer = msg.pointer;
               end
            end
            dcq_pkg::OP_TICK: run_tick();
            default: begin
               delay_ring.delete();
               countdown = '0;
            end
         endcase
         res.pending = (delay_ring.size() > 31) ? 5'd31 : 5'(delay_ring.size());
         due_results.push_back(res);
      endfunction

      function void check_result(dcq_result_type got);
         dcq_result_type want;
         if (due_results.size() == 0) begin
            flag($sformatf("result with no item outstanding: st=%0d v=%0d t=%0d w=%h p=%h dp=%0d",
                           got.status, got.valid, got.mtype, got.word, got.pointer,
                           got.pending));
            return;
         end
         want = due_results.pop_front();
         if (got !== want)
            flag($sformatf({"result mismatch: exp st=%0d v=%0d t=%0d w=%h p=%h dp=%0d",
                            " got st=%0d v=%0d t=%0d w=%h p=%h dp=%0d"},
                           want.status, want.valid, want.mtype, want.word, want.pointer,
                           want.pending, got.status, got.valid, got.mtype, got.word,
                           got.pointer, got.pending));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [1:0]                 req_op;
   logic [dcq_pkg::TYPE_W-1:0] req_msg_type_in;
   logic [dcq_pkg::WORD_W-1:0] req_msg_word_in;
   logic [dcq_pkg::WORD_W-1:0] req_msg_pointer_in;
   logic                       rsp_strobe;
   logic [1:0]                 rsp_status;
   logic                       rsp_msg_valid;
   logic [dcq_pkg::TYPE_W-1:0] rsp_msg_type_out;
   logic [dcq_pkg::WORD_W-1:0] rsp_msg_word_out;
   logic [dcq_pkg::WORD_W-1:0] rsp_msg_pointer_out;
   logic [4:0]                 rsp_delay_pending;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [2:0]                 paddr;
   logic [31:0]                pwdata;
   logic [31:0]                prdata;
   logic                       pready;

   command_queue_mirror mirror = new();
   int unsigned         cycles = 0;

   delayed_command_queue i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_msg_type_in     (req_msg_type_in),
      .req_msg_word_in     (req_msg_word_in),
      .req_msg_pointer_in  (req_msg_pointer_in),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_msg_valid       (rsp_msg_valid),
      .rsp_msg_type_out    (rsp_msg_type_out),
      .rsp_msg_word_out    (rsp_msg_word_out),
      .rsp_msg_pointer_out (rsp_msg_pointer_out),
      .rsp_delay_pending   (rsp_delay_pending),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         mirror.check_result({rsp_status, rsp_msg_valid, rsp_msg_type_out, rsp_msg_word_out,
                              rsp_msg_pointer_out, rsp_delay_pending});
   end

   task automatic idle(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         req_op = 2'($urandom_range(0, 3));
         req_msg_type_in = dcq_pkg::TYPE_W'($urandom_range(0, 31));
         req_msg_word_in = $urandom;
         req_msg_pointer_in = $urandom;
      end
   endtask

   // holds the item on the port until the block takes it
   task automatic issue(input logic [1:0] op, input logic [dcq_pkg::TYPE_W-1:0] t,
                        input logic [dcq_pkg::WORD_W-1:0] w,
                        input logic [dcq_pkg::WORD_W-1:0] p);
      @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_msg_type_in = t;
      req_msg_word_in = w;
      req_msg_pointer_in = p;
      do @(posedge clock); while (busy);
      mirror.accept_item(op, t, w, p);
   endtask

   task automatic drain();
      idle(1);
      while (mirror.due_count() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      mirror.write_reg(idx, value);
      // read back through a second transfer
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== mirror.reg_value(idx))
         mirror.flag($sformatf("register %0d read back %h, exp %h", idx, prdata,
                               mirror.reg_value(idx)));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic random_item(input int unsigned mode);
      int unsigned                r;
      logic [1:0]                 op;
      logic [dcq_pkg::TYPE_W-1:0] t;
      logic [dcq_pkg::WORD_W-1:0] w;
      r = $urandom_range(0, 99);
      case (mode)
         0: op = (r < 45) ? dcq_pkg::OP_SEND : (r < 75) ? dcq_pkg::OP_GET :
                 (r < 95) ? dcq_pkg::OP_TICK : dcq_pkg::OP_CLEAR;
         1: op = (r < 75) ? dcq_pkg::OP_SEND : (r < 80) ? dcq_pkg::OP_GET :
                 (r < 97) ? dcq_pkg::OP_TICK : dcq_pkg::OP_CLEAR;
         default:
            op = (r < 25) ? dcq_pkg::OP_SEND : (r < 75) ? dcq_pkg::OP_GET :
                 (r < 98) ? dcq_pkg::OP_TICK : dcq_pkg::OP_CLEAR;
      endcase
      t = ($urandom_range(0, 3) == 0) ? mirror.delay_code :
          dcq_pkg::TYPE_W'($urandom_range(0, 31));
      // delay commands mostly carry short counts so the ring keeps moving
      w = (t == mirror.delay_code && $urandom_range(0, 7) != 0) ?
          dcq_pkg::WORD_W'($urandom_range(0, 4)) : dcq_pkg::WORD_W'($urandom);
      issue(op, t, w, $urandom);
   endtask

   task automatic random_settings();
      drain();
      case ($urandom_range(0, 4))
         0: csr_write(dcq_pkg::REG_MASK, 32'h0000_0000);
         1: csr_write(dcq_pkg::REG_MASK, 32'hFFFF_FFFF);
         2: csr_write(dcq_pkg::REG_MASK, $urandom);
         3: csr_write(dcq_pkg::REG_MASK, 32'd1 << $urandom_range(0, 31));
         default: csr_write(dcq_pkg::REG_MASK, $urandom | $urandom);
      endcase
      case ($urandom_range(0, 2))
         0: csr_write(dcq_pkg::REG_CODE, 32'd0);
         1: csr_write(dcq_pkg::REG_CODE, 32'd31);
         default: csr_write(dcq_pkg::REG_CODE, $urandom_range(0, 31));
      endcase
   endtask

   initial begin
      int unsigned issued;
      int unsigned phase_len;
      int unsigned mode;
      int unsigned burst_left;
      reset = 1'b1;
      start = 1'b0;
      req_op = dcq_pkg::OP_SEND;
      req_msg_type_in = '0;
      req_msg_word_in = '0;
      req_msg_pointer_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: nothing delayed, delay code zero
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_SEND, 5'd0, 32'h0000_0000, 32'h0000_0000);
      issue(dcq_pkg::OP_SEND, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_CLEAR, 5'd0, 32'd0, 32'd0);
      drain();
      csr_write(dcq_pkg::REG_MASK, 32'hFFFF_FFFF);
      csr_write(dcq_pkg::REG_CODE, 32'd31);
      issue(dcq_pkg::OP_SEND, 5'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      issue(dcq_pkg::OP_SEND, 5'd31, 32'd0, 32'h1234_5678);
      issue(dcq_pkg::OP_SEND, 5'd12, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
      issue(dcq_pkg::OP_SEND, 5'd31, 32'd2, 32'd0);
      issue(dcq_pkg::OP_SEND, 5'd1, 32'h0000_0001, 32'h8000_0000);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_GET, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_SEND, 5'd31, 32'hFFFF_FFFF, 32'd7);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_TICK, 5'd0, 32'd0, 32'd0);
      issue(dcq_pkg::OP_CLEAR, 5'd0, 32'd0, 32'd0);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         random_settings();
         phase_len = $urandom_range(40, 120);
         if (phase_len > RANDOM_ITEMS - issued) phase_len = RANDOM_ITEMS - issued;
         mode = $urandom_range(0, 2);
         burst_left = 0;
         repeat (phase_len) begin
            if (burst_left == 0) begin
               idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
               burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            random_item(mode);
            issued++;
         end
         // now and then let every result land before carrying on
         if ($urandom_range(0, 2) == 0) drain();
      end

      drain();
      repeat (40) @(posedge clock);
      if (mirror.due_count() != 0)
         mirror.flag($sformatf("%0d results never arrived", mirror.due_count()));
      if (mirror.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
